FILE: rtl/core/vci_translate_route_table_macros.svh
// Assertion macros used by the checker file.
// Each macro expects clk and rst_n in scope.
`ifndef VCI_TRANSLATE_ROUTE_TABLE_MACROS_SVH
`define VCI_TRANSLATE_ROUTE_TABLE_MACROS_SVH

// Same-cycle implication, reset disables the check
`define VTRT_ASSERT_IMPL(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, reset disables the check
`define VTRT_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

FILE: rtl/core/vtrt_pkg.sv
`default_nettype none

package vtrt_pkg;

    // Request opcodes
    localparam logic OP_ROUTE = 1'b0;
    localparam logic OP_WRITE = 1'b1;

    // Configuration register indexes
    localparam logic CFG_VCI_LIMIT   = 1'b0;
    localparam logic CFG_NUM_OUTPUTS = 1'b1;

    // Result status codes
    localparam logic [2:0] ST_OK         = 3'd0;
    localparam logic [2:0] ST_VCI_RANGE  = 3'd1;
    localparam logic [2:0] ST_UNASSIGNED = 3'd2;
    localparam logic [2:0] ST_BAD_PORT   = 3'd3;
    localparam logic [2:0] ST_BAD_VCI    = 3'd4;

    // Widths of stored fields
    localparam int PORT_W = 5;
    localparam int VCI_W  = 16;

    // One table entry
    typedef struct packed {
        logic              valid;
        logic [PORT_W-1:0] port;
        logic [VCI_W-1:0]  vci;
    } entry_t;

endpackage

`default_nettype wire

FILE: rtl/core/vtrt_entry_ram.sv
`default_nettype none

// Single write port, single registered read port
module vtrt_entry_ram #(
    parameter int DEPTH  = 1024,
    parameter int ADDR_W = $clog2(DEPTH)
) (
    input  wire logic               clk,
    input  wire logic               we,
    input  wire logic [ADDR_W-1:0]  waddr,
    input  wire vtrt_pkg::entry_t   wdata,
    input  wire logic               re,
    input  wire logic [ADDR_W-1:0]  raddr,
    output vtrt_pkg::entry_t        rdata
);

    vtrt_pkg::entry_t mem [DEPTH];
    vtrt_pkg::entry_t rdata_reg;

    // write port
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    // read port, registered output
    always_ff @(posedge clk)
    begin
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

`default_nettype wire

FILE: rtl/core/vci_translate_route_table.sv
// An accepted request passes the table read, then the result register, before its result is valid.
// Throughput: one request per cycle unless stalled; all read the RAM, good writes also write it.
// Back-to-back write then route to the same VCI needs no forwarding: the write lands first.
// Reset: config registers return to vci_limit 1024 and num_outputs 16; then a sweep clears
// every entry, one per cycle, with in_stall held high.
`default_nettype none

module vci_translate_route_table #(
    parameter int TABLE_DEPTH = 1024,
    parameter int MAX_PORTS   = 16
) (
    input  wire logic        clk,
    input  wire logic        rst_n,
    // request channel
    input  wire logic        in_valid,
    output logic             in_stall,
    input  wire logic        op,
    input  wire logic [15:0] vci_in,
    input  wire logic [4:0]  port_in,
    input  wire logic [15:0] new_vci,
    // result channel
    output logic             out_valid,
    input  wire logic        out_stall,
    output logic [2:0]       status,
    output logic [3:0]       out_port,
    output logic [15:0]      vci_out,
    // configuration
    input  wire logic        cfg_we,
    input  wire logic        cfg_index,
    input  wire logic [10:0] cfg_data
);

    localparam int              AW        = $clog2(TABLE_DEPTH);
    localparam logic [AW-1:0]   LAST_ADDR = AW'(TABLE_DEPTH - 1);
    localparam logic [16:0]     DEPTH_LIM = 17'(TABLE_DEPTH);
    localparam logic [8:0]      PORT_LIM  = 9'(MAX_PORTS);

    // configuration registers
    logic [10:0] vci_limit_reg;
    logic [4:0]  num_outputs_reg;

    // clearing sweep
    logic          clearing_reg, clearing_next;
    logic [AW-1:0] clr_addr_reg, clr_addr_next;

    // lookup stage
    logic       s1_valid_reg, s1_valid_next;
    logic       s1_op_reg;
    logic       s1_range_ok_reg;
    logic [2:0] s1_wstatus_reg;

    // result register
    logic        out_valid_reg, out_valid_next;
    logic [2:0]  status_reg;
    logic [3:0]  out_port_reg;
    logic [15:0] vci_out_reg;

    logic             accept;
    logic             s1_advance;
    logic [16:0]      eff_limit;
    logic [8:0]       eff_ports;
    logic             range_ok;
    logic [2:0]       wstatus;
    logic             ram_we;
    logic [AW-1:0]    ram_waddr;
    vtrt_pkg::entry_t ram_wdata;
    vtrt_pkg::entry_t ram_rdata;
    logic [2:0]       res_status;
    logic [3:0]       res_port;
    logic [15:0]      res_vci;

    // handshake
    assign s1_advance = !out_valid_reg || !out_stall;
    assign in_stall   = clearing_reg || (s1_valid_reg && !s1_advance);
    assign accept     = in_valid && !in_stall;

    // effective limits, saturated to the table size and port count
    always_comb
    begin
        eff_limit = ({6'd0, vci_limit_reg} > DEPTH_LIM) ? DEPTH_LIM : {6'd0, vci_limit_reg};
        eff_ports = ({4'd0, num_outputs_reg} > PORT_LIM) ? PORT_LIM : {4'd0, num_outputs_reg};
    end

    // request checks: VCI range first, then the 1-based write port
    always_comb
    begin
        range_ok = {1'b0, vci_in} < eff_limit;
        priority if (!range_ok)
        begin
            wstatus = vtrt_pkg::ST_BAD_VCI;
        end
        else if (port_in == 5'd0 || {4'd0, port_in} > eff_ports)
        begin
            wstatus = vtrt_pkg::ST_BAD_PORT;
        end
        else
        begin
            wstatus = vtrt_pkg::ST_OK;
        end
    end

    // RAM write: clearing sweep or a good table write
    always_comb
    begin
        if (clearing_reg)
        begin
            ram_we    = 1'b1;
            ram_waddr = clr_addr_reg;
            ram_wdata = '0;
        end
        else
        begin
            ram_we          = accept && (op == vtrt_pkg::OP_WRITE)
                              && (wstatus == vtrt_pkg::ST_OK);
            ram_waddr       = vci_in[AW-1:0];
            ram_wdata.valid = 1'b1;
            ram_wdata.port  = port_in - 5'd1;
            ram_wdata.vci   = new_vci;
        end
    end

    vtrt_entry_ram #(
        .DEPTH  (TABLE_DEPTH),
        .ADDR_W (AW)
    ) u_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .re    (accept),
        .raddr (vci_in[AW-1:0]),
        .rdata (ram_rdata)
    );

    // result from the lookup stage
    always_comb
    begin
        res_status = vtrt_pkg::ST_OK;
        res_port   = 4'd0;
        res_vci    = 16'd0;
        if (s1_op_reg == vtrt_pkg::OP_WRITE)
        begin
            res_status = s1_wstatus_reg;
        end
        else if (!s1_range_ok_reg)
        begin
            res_status = vtrt_pkg::ST_VCI_RANGE;
        end
        else if (!ram_rdata.valid || {4'd0, ram_rdata.port} >= eff_ports)
        begin
            // unset, or port no longer in use
            res_status = vtrt_pkg::ST_UNASSIGNED;
        end
        else
        begin
            res_port = ram_rdata.port[3:0];
            res_vci  = ram_rdata.vci;
        end
    end

    // control next state
    always_comb
    begin
        clearing_next = clearing_reg;
        clr_addr_next = clr_addr_reg;
        if (clearing_reg)
        begin
            clr_addr_next = clr_addr_reg + 1'b1;
            if (clr_addr_reg == LAST_ADDR)
            begin
                clearing_next = 1'b0;
            end
        end

        // stage holds while blocked, loads on accept
        s1_valid_next = accept || (s1_valid_reg && !s1_advance);

        out_valid_next = out_valid_reg;
        if (s1_advance)
        begin
            out_valid_next = s1_valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vci_limit_reg   <= 11'd1024;
            num_outputs_reg <= 5'd16;
            clearing_reg    <= 1'b1;
            clr_addr_reg    <= '0;
            s1_valid_reg    <= 1'b0;
            out_valid_reg   <= 1'b0;
        end
        else
        begin
            if (cfg_we)
            begin
                unique case (cfg_index)
                    vtrt_pkg::CFG_VCI_LIMIT:   vci_limit_reg   <= cfg_data;
                    vtrt_pkg::CFG_NUM_OUTPUTS: num_outputs_reg <= cfg_data[4:0];
                    default:                   vci_limit_reg   <= vci_limit_reg;
                endcase
            end
            clearing_reg  <= clearing_next;
            clr_addr_reg  <= clr_addr_next;
            s1_valid_reg  <= s1_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            s1_op_reg       <= op;
            s1_range_ok_reg <= range_ok;
            s1_wstatus_reg  <= wstatus;
        end
        if (s1_advance && s1_valid_reg)
        begin
            status_reg   <= res_status;
            out_port_reg <= res_port;
            vci_out_reg  <= res_vci;
        end
    end

    assign out_valid = out_valid_reg;
    assign status    = status_reg;
    assign out_port  = out_port_reg;
    assign vci_out   = vci_out_reg;

endmodule

`default_nettype wire

FILE: rtl/core/vtrt_checker.sv
`default_nettype none

`include "vci_translate_route_table_macros.svh"

module vtrt_checker (
    input wire logic        clk,
    input wire logic        rst_n,
    input wire logic        in_valid,
    input wire logic        in_stall,
    input wire logic        out_valid,
    input wire logic        out_stall,
    input wire logic [2:0]  status,
    input wire logic [3:0]  out_port,
    input wire logic [15:0] vci_out
);

    // every accepted request is followed by out_valid high
    `VTRT_ASSERT_IMPL(a_result_follows, in_valid && !in_stall, ##2 out_valid, "request lost")

    // error results carry no route
    `VTRT_ASSERT_IMPL(a_err_zero, out_valid && status != vtrt_pkg::ST_OK,
        out_port == 4'd0 && vci_out == 16'd0, "error result with route data")

    // only defined status codes
    `VTRT_ASSERT_IMPL(a_status_code, out_valid,
        status == vtrt_pkg::ST_OK || status == vtrt_pkg::ST_VCI_RANGE
        || status == vtrt_pkg::ST_UNASSIGNED || status == vtrt_pkg::ST_BAD_PORT
        || status == vtrt_pkg::ST_BAD_VCI, "undefined status code")

    // stalled result holds
    `VTRT_ASSERT_NEXT(a_out_hold, out_valid && out_stall,
        out_valid && $stable(status) && $stable(out_port) && $stable(vci_out),
        "stalled result changed")

endmodule

bind vci_translate_route_table vtrt_checker u_vtrt_checker (.*);

`default_nettype wire

FILE: tb/tb_vci_translate_route_table.sv
`timescale 1ns / 100ps

module tb_vci_translate_route_table;

    localparam int TABLE_DEPTH = 1024;
    localparam int MAX_PORTS   = 16;
    localparam int CYCLE_LIMIT = 200000;
    localparam int DRAIN_WAIT  = 4;
    localparam int NUM_PHASES  = 8;
    localparam int NUM_DIRECTED = 20;
    localparam int RESET_PHASE_ITEMS = 250;

    // Phase plan: register settings, number of random requests, idling off
    localparam int PH_VCI_LIMIT [NUM_PHASES] = '{64, 1024, 0, 2047, 1, 1025, 300, 1024};
    localparam int PH_OUTPUTS   [NUM_PHASES] = '{4, 16, 0, 31, 1, 17, 9, 16};
    localparam int PH_ITEMS     [NUM_PHASES] = '{230, 230, 100, 230, 150, 200, 230, 230};
    localparam bit PH_NO_IDLE   [NUM_PHASES] = '{0, 1, 0, 0, 0, 0, 0, 0};

    typedef struct packed {
        logic [2:0]  status;
        logic [3:0]  port;
        logic [15:0] vci;
    } route_result_t;

    typedef struct packed {
        logic          opc;
        logic [15:0]   vci;
        logic [4:0]    port;
        logic [15:0]   nvci;
        logic          typed;
        route_result_t want;
    } stim_row_t;

    // Directed requests under the reset settings (1024 VCIs, 16 outputs).
    // typed rows carry their result; the rest go through the predictor.
    localparam stim_row_t DIRECTED [NUM_DIRECTED] = '{
        '{vtrt_pkg::OP_ROUTE, 16'd0,     5'd0,  16'h0000, 1'b1,
          '{vtrt_pkg::ST_UNASSIGNED, 4'd0, 16'h0000}},
        '{vtrt_pkg::OP_ROUTE, 16'd1023,  5'd31, 16'hFFFF, 1'b1,
          '{vtrt_pkg::ST_UNASSIGNED, 4'd0, 16'h0000}},
        '{vtrt_pkg::OP_ROUTE, 16'd1024,  5'd0,  16'h0000, 1'b1,
          '{vtrt_pkg::ST_VCI_RANGE, 4'd0, 16'h0000}},
        '{vtrt_pkg::OP_ROUTE, 16'hFFFF,  5'd1,  16'h0001, 1'b1,
          '{vtrt_pkg::ST_VCI_RANGE, 4'd0, 16'h0000}},
        '{vtrt_pkg::OP_WRITE, 16'hFFFF,  5'd1,  16'h0001, 1'b1,
          '{vtrt_pkg::ST_BAD_VCI, 4'd0, 16'h0000}},
        // VCI is checked before the port
        '{vtrt_pkg::OP_WRITE, 16'd1024,  5'd0,  16'h1111, 1'b1,
          '{vtrt_pkg::ST_BAD_VCI, 4'd0, 16'h0000}},
        '{vtrt_pkg::OP_WRITE, 16'd0,     5'd0,  16'h2222, 1'b1,
          '{vtrt_pkg::ST_BAD_PORT, 4'd0, 16'h0000}},
        '{vtrt_pkg::OP_WRITE, 16'd0,     5'd17, 16'h3333, 1'b1,
          '{vtrt_pkg::ST_BAD_PORT, 4'd0, 16'h0000}},
        '{vtrt_pkg::OP_WRITE, 16'd0,     5'd31, 16'hFFFF, 1'b1,
          '{vtrt_pkg::ST_BAD_PORT, 4'd0, 16'h0000}},
        // failed writes leave the entry unassigned
        '{vtrt_pkg::OP_ROUTE, 16'd0,     5'd0,  16'h0000, 1'b1,
          '{vtrt_pkg::ST_UNASSIGNED, 4'd0, 16'h0000}},
        '{vtrt_pkg::OP_WRITE, 16'd0,     5'd1,  16'hFFFF, 1'b1,
          '{vtrt_pkg::ST_OK, 4'd0, 16'h0000}},
        '{vtrt_pkg::OP_ROUTE, 16'd0,     5'd0,  16'h0000, 1'b1,
          '{vtrt_pkg::ST_OK, 4'd0, 16'hFFFF}},
        '{vtrt_pkg::OP_WRITE, 16'd1023,  5'd16, 16'h0000, 1'b1,
          '{vtrt_pkg::ST_OK, 4'd0, 16'h0000}},
        '{vtrt_pkg::OP_ROUTE, 16'd1023,  5'd0,  16'h0000, 1'b1,
          '{vtrt_pkg::ST_OK, 4'd15, 16'h0000}},
        '{vtrt_pkg::OP_WRITE, 16'd1023,  5'd16, 16'hA5A5, 1'b1,
          '{vtrt_pkg::ST_OK, 4'd0, 16'h0000}},
        // route ignores port_in and new_vci
        '{vtrt_pkg::OP_ROUTE, 16'd1023,  5'd31, 16'hFFFF, 1'b1,
          '{vtrt_pkg::ST_OK, 4'd15, 16'hA5A5}},
        '{vtrt_pkg::OP_WRITE, 16'h0155,  5'd11, 16'h5A5A, 1'b0,
          '{vtrt_pkg::ST_OK, 4'd0, 16'h0000}},
        '{vtrt_pkg::OP_ROUTE, 16'h0155,  5'd0,  16'h0000, 1'b0,
          '{vtrt_pkg::ST_OK, 4'd0, 16'h0000}},
        '{vtrt_pkg::OP_WRITE, 16'h02AA,  5'd6,  16'h1234, 1'b0,
          '{vtrt_pkg::ST_OK, 4'd0, 16'h0000}},
        '{vtrt_pkg::OP_ROUTE, 16'h02AA,  5'd20, 16'h4321, 1'b0,
          '{vtrt_pkg::ST_OK, 4'd0, 16'h0000}}
    };

    logic        clk;
    logic        rst_n = 1'b0;
    logic        in_valid = 1'b0;
    logic        in_stall;
    logic        op = vtrt_pkg::OP_ROUTE;
    logic [15:0] vci_in = '0;
    logic [4:0]  port_in = '0;
    logic [15:0] new_vci = '0;
    logic        out_valid;
    logic        out_stall = 1'b0;
    logic [2:0]  status;
    logic [3:0]  out_port;
    logic [15:0] vci_out;
    logic        cfg_we = 1'b0;
    logic        cfg_index = vtrt_pkg::CFG_VCI_LIMIT;
    logic [10:0] cfg_data = '0;

    bit            no_idle = 1'b0;
    int            mismatches = 0;
    int            cycles = 0;
    route_result_t pending_routes [$];

    // Shadow of the routing table and its registers
    logic [10:0] shadow_vci_limit = 11'd1024;
    logic [4:0]  shadow_outputs = 5'd16;
    bit          shadow_valid [TABLE_DEPTH];
    logic [3:0]  shadow_port [TABLE_DEPTH];
    logic [15:0] shadow_vci [TABLE_DEPTH];

    vci_translate_route_table #(
        .TABLE_DEPTH(TABLE_DEPTH),
        .MAX_PORTS(MAX_PORTS)
    ) u_top (
        .clk(clk),
        .rst_n(rst_n),
        .in_valid(in_valid),
        .in_stall(in_stall),
        .op(op),
        .vci_in(vci_in),
        .port_in(port_in),
        .new_vci(new_vci),
        .out_valid(out_valid),
        .out_stall(out_stall),
        .status(status),
        .out_port(out_port),
        .vci_out(vci_out),
        .cfg_we(cfg_we),
        .cfg_index(cfg_index),
        .cfg_data(cfg_data)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // Registers saturate at the table depth and the port count
    function automatic int usable_vcis();
        return (shadow_vci_limit > TABLE_DEPTH) ? TABLE_DEPTH : int'(shadow_vci_limit);
    endfunction

    function automatic int usable_ports();
        return (shadow_outputs > MAX_PORTS) ? MAX_PORTS : int'(shadow_outputs);
    endfunction

    // Table lookup or entry write; updates the shadow table on a good write
    function automatic route_result_t translate_request(logic opc, logic [15:0] vci,
                                                        logic [4:0] port, logic [15:0] nvci);
        route_result_t res;
        int lim;
        int nports;
        res = '0;
        res.status = vtrt_pkg::ST_OK;
        lim = usable_vcis();
        nports = usable_ports();
        if (opc == vtrt_pkg::OP_WRITE)
        begin
            if (int'(vci) >= lim)
                res.status = vtrt_pkg::ST_BAD_VCI;
            else if (port == 5'd0 || int'(port) - 1 >= nports)
                res.status = vtrt_pkg::ST_BAD_PORT;
            else
            begin
                shadow_valid[vci] = 1'b1;
                shadow_port[vci] = 4'(port - 5'd1);
                shadow_vci[vci] = nvci;
            end
        end
        else
        begin
            if (int'(vci) >= lim)
                res.status = vtrt_pkg::ST_VCI_RANGE;
            else if (!shadow_valid[vci] || int'(shadow_port[vci]) >= nports)
                res.status = vtrt_pkg::ST_UNASSIGNED;
            else
            begin
                res.port = shadow_port[vci];
                res.vci = shadow_vci[vci];
            end
        end
        return res;
    endfunction

    task automatic report_mismatch(input string field, input int got, input int want);
        $display("[%0t] mismatch on %s: got 0x%0h, expected 0x%0h", $time, field, got, want);
        mismatches++;
    endtask

    // Drive one request, wait for its accept, then queue its result
    task automatic send_request(input logic opc, input logic [15:0] vci, input logic [4:0] port,
                                input logic [15:0] nvci, input logic typed,
                                input route_result_t want);
        route_result_t predicted;
        int gap;
        gap = 0;
        while (!no_idle && $urandom_range(0, 99) < 22)
            gap++;
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid <= 1'b1;
        op <= opc;
        vci_in <= vci;
        port_in <= port;
        new_vci <= nvci;
        do
            @(posedge clk);
        while (in_stall);
        predicted = translate_request(opc, vci, port, nvci);
        pending_routes.push_back(typed ? want : predicted);
    endtask

    // Mostly a small hot set of VCIs so routes hit programmed entries,
    // plus the limit boundary, the whole table and the full 16-bit range
    task automatic send_random_request();
        logic       opc;
        logic [15:0] vci;
        logic [4:0] port;
        int lim;
        int nports;
        int hot_top;
        int pick;
        lim = usable_vcis();
        nports = usable_ports();
        opc = ($urandom_range(0, 99) < 40) ? vtrt_pkg::OP_WRITE : vtrt_pkg::OP_ROUTE;
        hot_top = (lim == 0) ? 15 : ((lim > 48) ? 47 : lim - 1);
        pick = $urandom_range(0, 99);
        if (pick < 60)
            vci = 16'($urandom_range(0, hot_top));
        else if (pick < 75)
            vci = (lim < 2) ? 16'($urandom_range(0, 3)) : 16'($urandom_range(lim - 2, lim + 1));
        else if (pick < 90)
            vci = 16'($urandom_range(0, TABLE_DEPTH - 1));
        else
            vci = 16'($urandom);
        if ($urandom_range(0, 99) < 75)
            port = 5'($urandom_range(1, (nports == 0) ? 1 : nports));
        else
            port = 5'($urandom_range(0, 31));
        send_request(opc, vci, port, 16'($urandom), 1'b0, '0);
    endtask

    // Register write once every outstanding result is back
    task automatic write_register(input logic idx, input logic [10:0] value);
        in_valid <= 1'b0;
        while (pending_routes.size() != 0)
            @(posedge clk);
        repeat (DRAIN_WAIT) @(posedge clk);
        cfg_we <= 1'b1;
        cfg_index <= idx;
        cfg_data <= value;
        @(posedge clk);
        cfg_we <= 1'b0;
        if (idx == vtrt_pkg::CFG_VCI_LIMIT)
            shadow_vci_limit = value;
        else
            shadow_outputs = 5'(value);
    endtask

    // Result checker and output stall
    always @(posedge clk)
    begin
        route_result_t want;
        if (rst_n && out_valid && !out_stall)
        begin
            if (pending_routes.size() == 0)
                report_mismatch("unexpected result status", int'(status), 0);
            else
            begin
                want = pending_routes.pop_front();
                if (status !== want.status)
                    report_mismatch("status", int'(status), int'(want.status));
                if (out_port !== want.port)
                    report_mismatch("out_port", int'(out_port), int'(want.port));
                if (vci_out !== want.vci)
                    report_mismatch("vci_out", int'(vci_out), int'(want.vci));
            end
        end
        out_stall <= !no_idle && ($urandom_range(0, 99) < 22);
    end

    // Watchdog
    always @(posedge clk)
    begin
        cycles++;
        if (cycles >= CYCLE_LIMIT)
        begin
            $display("TEST FAILED");
            $finish;
        end
    end

    initial
    begin
        for (int i = 0; i < TABLE_DEPTH; i++)
        begin
            shadow_valid[i] = 1'b0;
            shadow_port[i] = '0;
            shadow_vci[i] = '0;
        end
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;

        // directed requests, then random under the reset settings
        for (int i = 0; i < NUM_DIRECTED; i++)
            send_request(DIRECTED[i].opc, DIRECTED[i].vci, DIRECTED[i].port,
                         DIRECTED[i].nvci, DIRECTED[i].typed, DIRECTED[i].want);
        for (int i = 0; i < RESET_PHASE_ITEMS; i++)
            send_random_request();

        // random phases across register settings
        for (int p = 0; p < NUM_PHASES; p++)
        begin
            write_register(vtrt_pkg::CFG_VCI_LIMIT, 11'(PH_VCI_LIMIT[p]));
            write_register(vtrt_pkg::CFG_NUM_OUTPUTS, 11'(PH_OUTPUTS[p]));
            no_idle <= PH_NO_IDLE[p];
            for (int i = 0; i < PH_ITEMS[p]; i++)
                send_random_request();
        end

        // drain, then watch for stray results
        in_valid <= 1'b0;
        no_idle <= 1'b0;
        while (pending_routes.size() != 0)
            @(posedge clk);
        repeat (8) @(posedge clk);
        if (mismatches == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end

endmodule
